[sv/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Shared constants and the per-item control struct of the demosaic pipeline.
// ----------------------------------------------------------------------------
package bbd_pkg;

   localparam int MAX_SIDE_DEFAULT   = 1024;
   localparam int PIXEL_BITS_DEFAULT = 8;

   // Width of the side length register and its reset value.
   localparam int          SIDE_W     = 11;
   localparam logic [10:0] SIDE_RESET = 11'd32;
   localparam int          MIN_SIDE   = 2;

   // Decoded position of one item, built at input transfer time.
   typedef struct packed {
      logic emit;       // item carries a result
      logic clr;        // window is cleared before this item shifts in
      logic zero_pix;   // sample is forced to zero (flush or drain row)
      logic r_top;      // result pixel has a row above it
      logic r_bot;      // result pixel has a row below it
      logic c_left;     // result pixel has a column to its left
      logic c_right;    // result pixel has a column to its right
      logic r_odd;      // result pixel sits on an R G row
      logic c_odd;      // result pixel sits on an odd column
      logic last;       // result pixel is the last one of the frame
   } item_ctl_type;

endpackage

[sv/bayer_bilinear_demosaic_top.sv]
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic
// Streams a square GBRG raw frame in raster order and returns full RGB per
// pixel by bilinear interpolation over a 3x3 neighborhood.
// ----------------------------------------------------------------------------
// The block takes one raw sample per transfer on the req_ channel (even rows
// G B G B, odd rows R G R G) and returns red, green and blue for each pixel on
// the rsp_ channel, one transfer per clock when both sides keep up. Each
// result comes out on the input item that arrives one row plus one pixel
// later, so after the last pixel of a frame the source sends side_length + 1
// items with req_flush set to drain the remaining results; rsp_frame_last
// marks the last pixel. Inside, an item passes three register stages: the
// input stage, which also launches the line buffer read, the 3x3 window
// stage, and the result register, which drives rsp_valid. While both sides
// keep up, one item per clock is sustained because the line buffer has
// separate read and write ports, each used once per item. Neighbors outside
// the frame count as zero and averages are truncated. The line buffer has no
// clearing pass and is usable immediately after reset. Write csr_data with
// csr_we only while the block is idle; side lengths below 2 act as 2 and
// those above MAX_SIDE act as MAX_SIDE.
module bayer_bilinear_demosaic_top
   import bbd_pkg::*;
#(
   parameter int MAX_SIDE   = MAX_SIDE_DEFAULT,
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [SIDE_W-1:0]     csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   input  logic                  req_flush,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_BITS-1:0] rsp_red,
   output logic [PIXEL_BITS-1:0] rsp_green,
   output logic [PIXEL_BITS-1:0] rsp_blue,
   output logic                  rsp_frame_last
);

   localparam int PB     = PIXEL_BITS;
   localparam int POS_W  = $clog2(MAX_SIDE + 2);
   localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   logic                take;
   logic [POS_W-1:0]    scan_col;
   item_ctl_type        scan_ctl;

   // Input stage registers.
   logic                s1_valid_ff, s1_valid_in;
   item_ctl_type        s1_ctl_ff, s1_ctl_in;
   logic [PB-1:0]       s1_pix_ff, s1_pix_in;
   logic [ADDR_W-1:0]   s1_addr_ff, s1_addr_in;
   logic                s1_fwd_ff, s1_fwd_in;
   logic [PB-1:0]       s1_fwd_top_ff, s1_fwd_top_in;
   logic [PB-1:0]       s1_fwd_mid_ff, s1_fwd_mid_in;

   logic                s1_go, s2_free;
   logic [2*PB-1:0]     line_rd;
   logic [PB-1:0]       s1_top, s1_mid;

   // The scanner decodes every offered item; its position moves only on a transfer.
   bbd_scan #(
      .MAX_SIDE (MAX_SIDE)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .take     (take),
      .flush    (req_flush),
      .col      (scan_col),
      .ctl      (scan_ctl)
   );

   // The input stage frees up whenever its item moves on to the window stage.
   assign s1_go     = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s1_go;
   assign take      = req_valid && req_ready;

   // The line buffer holds the two previous rows side by side: the upper half
   // of a word is two rows back, the lower half one row back. Each item reads
   // its column when it is transferred in and writes the column back as it
   // leaves the input stage, moving the older row up and its own sample in.
   bbd_ram #(
      .WIDTH (2 * PB),
      .DEPTH (MAX_SIDE)
   ) u_line (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data ({s1_mid, s1_pix_ff}),
      .rd_en   (take),
      .rd_addr (scan_col[ADDR_W-1:0]),
      .rd_data (line_rd)
   );

   // When successive items fall on the same column, as at a frame restart, the
   // next item can read the very column that the leaving item writes at the
   // same edge; that data comes from the leaving item instead of the buffer.
   assign s1_top = s1_fwd_ff ? s1_fwd_top_ff : line_rd[2*PB-1:PB];
   assign s1_mid = s1_fwd_ff ? s1_fwd_mid_ff : line_rd[PB-1:0];

   always_comb begin
      s1_valid_in   = take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s1_ctl_in     = s1_ctl_ff;
      s1_pix_in     = s1_pix_ff;
      s1_addr_in    = s1_addr_ff;
      s1_fwd_in     = s1_fwd_ff;
      s1_fwd_top_in = s1_fwd_top_ff;
      s1_fwd_mid_in = s1_fwd_mid_ff;
      if (take) begin
         s1_ctl_in     = scan_ctl;
         s1_pix_in     = scan_ctl.zero_pix ? '0 : req_pixel;
         s1_addr_in    = scan_col[ADDR_W-1:0];
         s1_fwd_in     = s1_go && (s1_addr_ff == scan_col[ADDR_W-1:0]);
         s1_fwd_top_in = s1_mid;
         s1_fwd_mid_in = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff     <= s1_ctl_in;
      s1_pix_ff     <= s1_pix_in;
      s1_addr_ff    <= s1_addr_in;
      s1_fwd_ff     <= s1_fwd_in;
      s1_fwd_top_ff <= s1_fwd_top_in;
      s1_fwd_mid_ff <= s1_fwd_mid_in;
   end

   // Window stage and result register.
   bbd_interp #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_interp (
      .clock          (clock),
      .reset          (reset),
      .load           (s1_go),
      .load_ctl       (s1_ctl_ff),
      .load_top       (s1_top),
      .load_mid       (s1_mid),
      .load_pix       (s1_pix_ff),
      .stage_free     (s2_free),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_last (rsp_frame_last)
   );

`ifndef SYNTHESIS
   // Forwarding is only armed by a transfer that coincides with a write.
   a_fwd_needs_write: assert property (@(posedge clock) disable iff (reset)
      (take && !s1_go) |=> !s1_fwd_ff)
      else $error("line forward armed without a write");

   // An item held in the input stage is never lost.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> s1_valid_ff)
      else $error("input stage item dropped");

   // A held input stage item keeps its line buffer address.
   a_s1_addr: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> $stable(s1_addr_ff))
      else $error("input stage address changed while held");
`endif

endmodule

[sv/bbd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bbd_scan.sv]
// ----------------------------------------------------------------------------
// Demosaic raster scanner
// Holds the side length register and the raster position, and decodes the
// position of each incoming item into its result coordinates and edge flags.
// ----------------------------------------------------------------------------
module bbd_scan
   import bbd_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [SIDE_W-1:0]                    csr_data,
   input  logic                                 take,
   input  logic                                 flush,
   output logic [$clog2(MAX_SIDE + 2)-1:0]      col,
   output item_ctl_type                         ctl
);

   localparam int POS_W = $clog2(MAX_SIDE + 2);

   logic [SIDE_W-1:0] side_ff, side_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic              after_last_ff, after_last_in;

   logic [POS_W-1:0]  side_eff, side_m1, side_p1;
   logic              restart;
   logic [POS_W-1:0]  ir, ic, ic_nx, r, c;
   logic              emit, last;

   // Out-of-range side lengths act as the nearest legal one.
   always_comb begin
      if (side_ff < SIDE_W'(MIN_SIDE)) begin
         side_eff = POS_W'(MIN_SIDE);
      end else if (32'(side_ff) > MAX_SIDE) begin
         side_eff = POS_W'(MAX_SIDE);
      end else begin
         side_eff = POS_W'(side_ff);
      end
   end

   assign side_m1 = side_eff - POS_W'(1);
   assign side_p1 = side_eff + POS_W'(1);

   // A position that is not valid for the current side restarts the frame.
   assign restart = (col_ff >= side_eff) || (row_ff > side_p1) ||
                    ((row_ff == side_p1) && (col_ff != '0));
   assign ir      = restart ? '0 : row_ff;
   assign ic      = restart ? '0 : col_ff;
   assign ic_nx   = ic + POS_W'(1);

   assign emit = (ir >= POS_W'(2)) || ((ir == POS_W'(1)) && (ic != '0));

   // The result trails the input by one row and one pixel.
   assign r = (ic != '0) ? ir - POS_W'(1) : ir - POS_W'(2);
   assign c = (ic != '0) ? ic - POS_W'(1) : side_m1;

   assign last = (r == side_m1) && (c == side_m1);

   always_comb begin
      ctl.emit     = emit;
      ctl.clr      = restart || after_last_ff;
      ctl.zero_pix = flush || (ir >= side_eff);
      ctl.r_top    = (r != '0);
      ctl.r_bot    = (r != side_m1);
      ctl.c_left   = (c != '0);
      ctl.c_right  = (c != side_m1);
      ctl.r_odd    = r[0];
      ctl.c_odd    = c[0];
      ctl.last     = last;
   end

   assign col = ic;

   always_comb begin
      side_in       = csr_we ? csr_data : side_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      after_last_in = after_last_ff;
      if (take) begin
         after_last_in = 1'b0;
         if (emit && last) begin
            row_in        = '0;
            col_in        = '0;
            after_last_in = 1'b1;
         end else if (ic_nx >= side_eff) begin
            row_in = ir + POS_W'(1);
            col_in = '0;
         end else begin
            row_in = ir;
            col_in = ic_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff       <= SIDE_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         after_last_ff <= 1'b1;
      end else begin
         side_ff       <= side_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         after_last_ff <= after_last_in;
      end
   end

`ifndef SYNTHESIS
   // The stored row never runs past the drain row of the largest frame.
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      take |=> (32'(row_ff) <= MAX_SIDE + 1))
      else $error("scan row beyond drain row");

   // The end of a frame always brings the position back to the origin.
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (take && emit && last) |=> (row_ff == '0) && (col_ff == '0) && after_last_ff)
      else $error("frame end did not return to origin");
`endif

endmodule

[sv/bbd_interp.sv]
// ----------------------------------------------------------------------------
// Demosaic window and interpolator
// Holds the 3x3 neighborhood, forms the missing colors by bilinear averages
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module bbd_interp
   import bbd_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  item_ctl_type          load_ctl,
   input  logic [PIXEL_BITS-1:0] load_top,
   input  logic [PIXEL_BITS-1:0] load_mid,
   input  logic [PIXEL_BITS-1:0] load_pix,
   output logic                  stage_free,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [PIXEL_BITS-1:0] rsp_red,
   output logic [PIXEL_BITS-1:0] rsp_green,
   output logic [PIXEL_BITS-1:0] rsp_blue,
   output logic                  rsp_frame_last
);

   localparam int PB = PIXEL_BITS;

   logic [PB-1:0] win_ff [3][3];
   logic [PB-1:0] win_in [3][3];
   logic          s2_valid_ff, s2_valid_in;
   item_ctl_type  s2_ctl_ff, s2_ctl_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic          last_ff, last_in;

   logic          out_free, s2_go;
   logic [PB-1:0] ul, uc, ur, cl, cc, cr, ll, lc, lr;
   logic [PB:0]   sum_vert, sum_horz;
   logic [PB+1:0] sum_diag, sum_cross;
   logic [PB-1:0] avg_vert, avg_horz, avg_diag, avg_cross;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s2_go      = s2_valid_ff && (out_free || !s2_ctl_ff.emit);
   assign stage_free = !s2_valid_ff || s2_go;

   // Window shifts left by one column; a frame restart empties it first.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][0];
         win_in[k][1] = win_ff[k][1];
         win_in[k][2] = win_ff[k][2];
         if (load) begin
            win_in[k][0] = load_ctl.clr ? '0 : win_ff[k][1];
            win_in[k][1] = load_ctl.clr ? '0 : win_ff[k][2];
         end
      end
      if (load) begin
         win_in[0][2] = load_top;
         win_in[1][2] = load_mid;
         win_in[2][2] = load_pix;
      end
   end

   assign s2_valid_in = load ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
   assign s2_ctl_in   = load ? load_ctl : s2_ctl_ff;

   // Neighbors outside the frame count as zero.
   assign ul = (s2_ctl_ff.r_top && s2_ctl_ff.c_left)  ? win_ff[0][0] : '0;
   assign uc =  s2_ctl_ff.r_top                       ? win_ff[0][1] : '0;
   assign ur = (s2_ctl_ff.r_top && s2_ctl_ff.c_right) ? win_ff[0][2] : '0;
   assign cl =  s2_ctl_ff.c_left                      ? win_ff[1][0] : '0;
   assign cc =  win_ff[1][1];
   assign cr =  s2_ctl_ff.c_right                     ? win_ff[1][2] : '0;
   assign ll = (s2_ctl_ff.r_bot && s2_ctl_ff.c_left)  ? win_ff[2][0] : '0;
   assign lc =  s2_ctl_ff.r_bot                       ? win_ff[2][1] : '0;
   assign lr = (s2_ctl_ff.r_bot && s2_ctl_ff.c_right) ? win_ff[2][2] : '0;

   assign sum_vert  = {1'b0, uc} + {1'b0, lc};
   assign sum_horz  = {1'b0, cl} + {1'b0, cr};
   assign sum_diag  = {2'b00, ul} + {2'b00, ur} + {2'b00, ll} + {2'b00, lr};
   assign sum_cross = {1'b0, sum_vert} + {1'b0, sum_horz};

   assign avg_vert  = sum_vert[PB:1];
   assign avg_horz  = sum_horz[PB:1];
   assign avg_diag  = sum_diag[PB+1:2];
   assign avg_cross = sum_cross[PB+1:2];

   always_comb begin
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      last_in  = last_ff;
      if (s2_go && s2_ctl_ff.emit) begin
         last_in = s2_ctl_ff.last;
         case ({s2_ctl_ff.r_odd, s2_ctl_ff.c_odd})
            2'b00: begin
               green_in = cc;
               blue_in  = avg_horz;
               red_in   = avg_vert;
            end
            2'b01: begin
               blue_in  = cc;
               red_in   = avg_diag;
               green_in = avg_cross;
            end
            2'b10: begin
               red_in   = cc;
               blue_in  = avg_diag;
               green_in = avg_cross;
            end
            default: begin
               green_in = cc;
               blue_in  = avg_vert;
               red_in   = avg_horz;
            end
         endcase
      end
   end

   assign rsp_valid_in = (s2_go && s2_ctl_ff.emit) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      s2_ctl_ff <= s2_ctl_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_frame_last = last_ff;

`ifndef SYNTHESIS
   // A result-carrying item waiting on a full output stage is kept.
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_ctl_ff.emit && !out_free) |=> s2_valid_ff)
      else $error("pending result dropped from window stage");

   // The window only moves when the stage it feeds can take a new item.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> stage_free)
      else $error("window loaded while stage busy");
`endif

endmodule
